### design/admlr_pkg.sv
// Shared types, constants and sample conversion for the downmix resampler.
package admlr_pkg;

  localparam int unsigned NUM_CH_PORTS = 8;
  localparam int unsigned Q_W          = 32;
  localparam int unsigned SUM_W        = 35;
  localparam int unsigned RATE_W       = 19;
  localparam int unsigned PHASE_W      = 20;
  localparam int unsigned DVD_W        = 52;
  localparam int unsigned DIV_STEPS    = 52;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned SCALED_W     = 48;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 19;

  localparam logic [RATE_W-1:0] RATE_MIN = 19'd8000;
  localparam logic [RATE_W-1:0] RATE_MAX = 19'd384000;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;
  localparam logic [1:0] FMT_F32 = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_CHANNELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_RATE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_RATE      = 3'd4;

  localparam logic signed [Q_W-1:0] Q_POS_SAT = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_NEG_SAT = 32'sh8000_0000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;
  localparam logic signed [OUT_W-1:0] OUT_SCALE = 16'sd32767;
  localparam logic [SCALED_W-1:0] ROUND_BIAS = 48'h000_0FFF_FFFF;

  typedef struct packed {
    logic load_in;
    logic norm_acc;
    logic mdiv_start;
    logic div_step;
    logic mix;
    logic mul;
    logic interp;
    logic bypass;
    logic scale;
    logic out_load;
    logic finish;
  } admlr_cmd_t;

  typedef struct packed {
    logic rates_eq;
    logic need_div;
    logic ch_last;
    logic p_lt_dr;
    logic out_free;
  } admlr_sts_t;

  function automatic logic signed [Q_W-1:0] to_q(input logic [31:0] raw,
                                                  input logic [1:0]  fmt);
    logic        neg;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] m;
    logic [31:0] mag;
    logic [2:0]  ls;
    logic [4:0]  rs;
    logic signed [Q_W-1:0] r;
    neg = raw[31];
    ex  = raw[30:23];
    man = raw[22:0];
    m   = {1'b1, man};
    ls  = 3'(ex - 8'd122);
    rs  = 5'(8'd122 - ex);
    mag = '0;
    unique case (fmt)
      FMT_U8:  r = {{3{~raw[7]}}, ~raw[7], raw[6:0], 21'b0};
      FMT_S16: r = {{3{raw[15]}}, raw[15:0], 13'b0};
      FMT_S32: r = {{3{raw[31]}}, raw[31:3]};
      default: begin
        if (ex == 8'd255) begin
          r = (man != '0) ? '0 : (neg ? Q_NEG_SAT : Q_POS_SAT);
        end else if (ex == 8'd0) begin
          r = '0;
        end else if (ex >= 8'd130) begin
          r = neg ? Q_NEG_SAT : Q_POS_SAT;
        end else begin
          if (ex >= 8'd122) begin
            mag = {8'b0, m} << ls;
          end else if (ex <= 8'd98) begin
            mag = '0;
          end else begin
            mag = {8'b0, m >> rs};
          end
          r = neg ? -$signed(mag) : $signed(mag);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
    logic [RATE_W-1:0] c;
    if (r < RATE_MIN) begin
      c = RATE_MIN;
    end else if (r > RATE_MAX) begin
      c = RATE_MAX;
    end else begin
      c = r;
    end
    return c;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SCALED_W-1:0] s);
    logic signed [SCALED_W-1:0] t;
    logic signed [SCALED_W-29:0] v;
    logic signed [OUT_W-1:0] o;
    t = s[SCALED_W-1] ? (s + $signed(ROUND_BIAS)) : s;
    v = t[SCALED_W-1:28];
    if (v > 20'sd32767) begin
      o = OUT_MAX;
    end else if (v < -20'sd32768) begin
      o = OUT_MIN;
    end else begin
      o = v[OUT_W-1:0];
    end
    return o;
  endfunction

endpackage

### design/audio_downmix_linear_resampler.sv
// Top level of the audio downmix and linear interpolation resampler.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//  in      | in        | in_valid_i/in_stall_o  | ch0..ch7_raw_i, silent_i
//  out     | out       | out_valid_o/out_stall_i| left/right_sample_o, run_last_o
//
// With mono averaging over two or more channels the 52-step shift-subtract
// divider runs once per frame; it runs again for each interpolated output word.
// Reset clears the interpolation history; the first frame is its own predecessor.
// A stalled output holds the controller in its emit step; no state is lost.
module audio_downmix_linear_resampler import admlr_pkg::*; #(
  parameter int unsigned MAX_SRC_CHANNELS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [31:0]             ch0_raw_i,
  input  logic [31:0]             ch1_raw_i,
  input  logic [31:0]             ch2_raw_i,
  input  logic [31:0]             ch3_raw_i,
  input  logic [31:0]             ch4_raw_i,
  input  logic [31:0]             ch5_raw_i,
  input  logic [31:0]             ch6_raw_i,
  input  logic [31:0]             ch7_raw_i,
  input  logic                    silent_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] left_sample_o,
  output logic signed [OUT_W-1:0] right_sample_o,
  output logic                    run_last_o
);

  localparam int unsigned ChIdxW = (MAX_SRC_CHANNELS > 1) ? $clog2(MAX_SRC_CHANNELS) : 1;

  admlr_cmd_t cmd;
  admlr_sts_t sts;
  logic [ChIdxW-1:0] ch_idx;
  logic [NUM_CH_PORTS-1:0][31:0] in_raw;

  assign in_raw = {ch7_raw_i, ch6_raw_i, ch5_raw_i, ch4_raw_i,
                   ch3_raw_i, ch2_raw_i, ch1_raw_i, ch0_raw_i};

  admlr_ctrl #(
    .ChIdxW (ChIdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .ch_idx_o   (ch_idx)
  );

  admlr_dp #(
    .MaxCh  (MAX_SRC_CHANNELS),
    .ChIdxW (ChIdxW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_raw_i       (in_raw),
    .silent_i       (silent_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .run_last_o     (run_last_o),
    .cmd_i          (cmd),
    .ch_idx_i       (ch_idx),
    .sts_o          (sts)
  );

endmodule

### design/admlr_ctrl.sv
// Sequencing state machine for the downmix resampler.
module admlr_ctrl import admlr_pkg::*; #(
  parameter int unsigned ChIdxW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  admlr_sts_t        sts_i,
  output admlr_cmd_t        cmd_o,
  output logic [ChIdxW-1:0] ch_idx_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_NORM   = 12'b0000_0000_0010,
    S_MSTART = 12'b0000_0000_0100,
    S_MDIV   = 12'b0000_0000_1000,
    S_MIX    = 12'b0000_0001_0000,
    S_CHECK  = 12'b0000_0010_0000,
    S_MUL    = 12'b0000_0100_0000,
    S_IDIV   = 12'b0000_1000_0000,
    S_INTERP = 12'b0001_0000_0000,
    S_SCALE  = 12'b0010_0000_0000,
    S_EMIT   = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [ChIdxW-1:0] ch_q, ch_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              div_done;

  assign div_done   = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign in_stall_o = (state_q != S_IDLE);
  assign ch_idx_o   = ch_q;

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          ch_d          = '0;
          state_d       = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.norm_acc = 1'b1;
        if (sts_i.ch_last) begin
          state_d = sts_i.need_div ? S_MSTART : S_MIX;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      S_MSTART: begin
        cmd_o.mdiv_start = 1'b1;
        cnt_d            = '0;
        state_d          = S_MDIV;
      end
      S_MDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (div_done) begin
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.rates_eq) begin
          cmd_o.bypass = 1'b1;
          state_d      = S_SCALE;
        end else if (sts_i.p_lt_dr) begin
          state_d = S_MUL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = S_IDIV;
      end
      S_IDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (div_done) begin
          state_d = S_INTERP;
        end
      end
      S_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.rates_eq ? S_FIN : S_CHECK;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output word overwritten");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DIV_STEPS))
    else $error("divide step count out of range");

endmodule

### design/admlr_dp.sv
// Normalize, mix, interpolate, divide and scale datapath with output register.
module admlr_dp import admlr_pkg::*; #(
  parameter int unsigned MaxCh  = 8,
  parameter int unsigned ChIdxW = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic [NUM_CH_PORTS-1:0][31:0] in_raw_i,
  input  logic                        silent_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic signed [OUT_W-1:0]     left_sample_o,
  output logic signed [OUT_W-1:0]     right_sample_o,
  output logic                        run_last_o,
  input  admlr_cmd_t                  cmd_i,
  input  logic [ChIdxW-1:0]           ch_idx_i,
  output admlr_sts_t                  sts_o
);

  logic [1:0]        fmt_q;
  logic [3:0]        src_ch_q;
  logic [1:0]        dst_ch_q;
  logic [RATE_W-1:0] src_rate_q, dst_rate_q;

  logic [31:0]       ch_q [MaxCh];
  logic              silent_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [Q_W-1:0]   c0_q, c1_q;
  logic signed [Q_W-1:0]   cur_l_q, cur_r_q, a_l_q, a_r_q, v_l_q, v_r_q;
  logic signed [Q_W-1:0]   prev_l_q, prev_r_q;
  logic              have_prev_q;
  logic [RATE_W-1:0] phase_q;
  logic [PHASE_W-1:0] p_q;
  logic              mono_div_q;
  logic              sign_l_q, sign_r_q;
  logic [DVD_W-1:0]  dvd_l_q, dvd_r_q;
  logic [RATE_W-1:0] rem_l_q, rem_r_q;
  logic signed [SCALED_W-1:0] s_l_q, s_r_q;
  logic              out_valid_q, last_q;
  logic signed [OUT_W-1:0] left_q, right_q;

  logic [3:0]        sc;
  logic              stereo;
  logic [RATE_W-1:0] sr, dr, divisor;
  logic signed [Q_W-1:0] qv, mono, cur_l, cur_r;
  logic [SUM_W-1:0]  sum_mag;
  logic signed [Q_W:0] diff_l, diff_r;
  logic [Q_W:0]      mag_l, mag_r;
  logic [RATE_W:0]   t_l, t_r;
  logic              ge_l, ge_r;
  logic [Q_W:0]      quo_l, quo_r;
  logic signed [Q_W+1:0] sum_vl, sum_vr;
  logic [PHASE_W:0]  p_next;

  always_comb begin
    if (src_ch_q == 4'd0) begin
      sc = 4'd1;
    end else if (src_ch_q > 4'(MaxCh)) begin
      sc = 4'(MaxCh);
    end else begin
      sc = src_ch_q;
    end
  end

  assign stereo  = dst_ch_q[1];
  assign sr      = clamp_rate(src_rate_q);
  assign dr      = clamp_rate(dst_rate_q);
  assign divisor = mono_div_q ? RATE_W'(sc) : dr;
  assign qv      = to_q(ch_q[ch_idx_i], fmt_q);
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign p_next  = {1'b0, p_q} + (PHASE_W+1)'(sr);

  assign sts_o.rates_eq = (sr == dr);
  assign sts_o.need_div = !stereo && (sc > 4'd1);
  assign sts_o.ch_last  = (4'(ch_idx_i) == sc - 4'd1);
  assign sts_o.p_lt_dr  = (p_q < PHASE_W'(dr));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    quo_l = dvd_l_q[Q_W:0];
    quo_r = dvd_r_q[Q_W:0];
    mono  = sts_o.need_div ? (sum_q[SUM_W-1] ? -$signed(quo_l[Q_W-1:0])
                                             : $signed(quo_l[Q_W-1:0])) : c0_q;
    if (silent_q) begin
      cur_l = '0;
      cur_r = '0;
    end else if (!stereo) begin
      cur_l = mono;
      cur_r = '0;
    end else if (sc >= 4'd2) begin
      cur_l = c0_q;
      cur_r = c1_q;
    end else begin
      cur_l = mono;
      cur_r = mono;
    end
    diff_l = (Q_W+1)'(cur_l_q) - (Q_W+1)'(a_l_q);
    diff_r = (Q_W+1)'(cur_r_q) - (Q_W+1)'(a_r_q);
    mag_l  = diff_l[Q_W] ? (Q_W+1)'(-diff_l) : (Q_W+1)'(diff_l);
    mag_r  = diff_r[Q_W] ? (Q_W+1)'(-diff_r) : (Q_W+1)'(diff_r);
    t_l    = {rem_l_q, dvd_l_q[DVD_W-1]};
    t_r    = {rem_r_q, dvd_r_q[DVD_W-1]};
    ge_l   = (t_l >= (RATE_W+1)'(divisor));
    ge_r   = (t_r >= (RATE_W+1)'(divisor));
    sum_vl = (Q_W+2)'(a_l_q) + (sign_l_q ? -$signed((Q_W+2)'(quo_l))
                                         : $signed((Q_W+2)'(quo_l)));
    sum_vr = (Q_W+2)'(a_r_q) + (sign_r_q ? -$signed((Q_W+2)'(quo_r))
                                         : $signed((Q_W+2)'(quo_r)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_S16;
      src_ch_q    <= 4'd2;
      dst_ch_q    <= 2'd2;
      src_rate_q  <= 19'd48000;
      dst_rate_q  <= 19'd48000;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      mono_div_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SAMPLE_FORMAT: fmt_q      <= cfg_wdata_i[1:0];
          REG_SRC_CHANNELS:  src_ch_q   <= cfg_wdata_i[3:0];
          REG_DST_CHANNELS:  dst_ch_q   <= cfg_wdata_i[1:0];
          REG_SRC_RATE:      src_rate_q <= cfg_wdata_i;
          REG_DST_RATE:      dst_rate_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.mdiv_start) begin
        mono_div_q <= 1'b1;
      end else if (cmd_i.mul) begin
        mono_div_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        have_prev_q <= 1'b1;
        prev_l_q    <= cur_l_q;
        if (stereo) begin
          prev_r_q <= cur_r_q;
        end
        if (!sts_o.rates_eq) begin
          phase_q <= sts_o.p_lt_dr ? '0 : RATE_W'(p_q - PHASE_W'(dr));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int i = 0; i < MaxCh; i++) begin
        ch_q[i] <= in_raw_i[i];
      end
      silent_q <= silent_i;
      sum_q    <= '0;
    end
    if (cmd_i.norm_acc) begin
      sum_q <= sum_q + SUM_W'(qv);
      if (ch_idx_i == '0) begin
        c0_q <= qv;
      end
      if (4'(ch_idx_i) == 4'd1) begin
        c1_q <= qv;
      end
    end
    if (cmd_i.mdiv_start) begin
      dvd_l_q <= DVD_W'(sum_mag);
      rem_l_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_l_q <= {dvd_l_q[DVD_W-2:0], ge_l};
      rem_l_q <= ge_l ? RATE_W'(t_l - (RATE_W+1)'(divisor)) : t_l[RATE_W-1:0];
      dvd_r_q <= {dvd_r_q[DVD_W-2:0], ge_r};
      rem_r_q <= ge_r ? RATE_W'(t_r - (RATE_W+1)'(divisor)) : t_r[RATE_W-1:0];
    end
    if (cmd_i.mix) begin
      cur_l_q <= cur_l;
      cur_r_q <= cur_r;
      a_l_q   <= have_prev_q ? prev_l_q : cur_l;
      a_r_q   <= have_prev_q ? prev_r_q : cur_r;
      p_q     <= have_prev_q ? PHASE_W'(phase_q) : '0;
    end
    if (cmd_i.mul) begin
      dvd_l_q  <= DVD_W'(mag_l * p_q[RATE_W-1:0]);
      dvd_r_q  <= DVD_W'(mag_r * p_q[RATE_W-1:0]);
      rem_l_q  <= '0;
      rem_r_q  <= '0;
      sign_l_q <= diff_l[Q_W];
      sign_r_q <= diff_r[Q_W];
    end
    if (cmd_i.interp) begin
      v_l_q <= sum_vl[Q_W-1:0];
      v_r_q <= sum_vr[Q_W-1:0];
    end
    if (cmd_i.bypass) begin
      v_l_q <= cur_l_q;
      v_r_q <= cur_r_q;
    end
    if (cmd_i.scale) begin
      s_l_q <= SCALED_W'(v_l_q * OUT_SCALE);
      s_r_q <= SCALED_W'(v_r_q * OUT_SCALE);
    end
    if (cmd_i.out_load) begin
      left_q  <= to_out(s_l_q);
      right_q <= stereo ? to_out(s_r_q) : '0;
      last_q  <= sts_o.rates_eq || (p_next >= (PHASE_W+1)'(dr));
      if (!sts_o.rates_eq) begin
        p_q <= p_next[PHASE_W-1:0];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;
  assign run_last_o     = last_q;

  a_phase_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < RATE_MAX)
    else $error("phase exceeds rate bound");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> divisor != '0)
    else $error("divide by zero");

endmodule
